>>> rtl/rcpwm_pkg.sv
// ----------------------------------------------------------------------------
// rcpwm_pkg
// Shared types and constants of the two-channel RC pulse-width decoder.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

	localparam int REG_BITS = 16;
	localparam int IDX_BITS = 3;
	localparam int PCT_BITS = 7;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_TIMEOUT   = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_VALID_MIN = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_VALID_MAX = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_STEER_MIN = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_STEER_MAX = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_THR_MIN   = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_THR_MAX   = 3'd6;

	// register reset values
	localparam logic [REG_BITS-1:0] RST_TIMEOUT   = 16'd25000;
	localparam logic [REG_BITS-1:0] RST_VALID_MIN = 16'd900;
	localparam logic [REG_BITS-1:0] RST_VALID_MAX = 16'd2200;
	localparam logic [REG_BITS-1:0] RST_STEER_MIN = 16'd960;
	localparam logic [REG_BITS-1:0] RST_STEER_MAX = 16'd1950;
	localparam logic [REG_BITS-1:0] RST_THR_MIN   = 16'd1100;
	localparam logic [REG_BITS-1:0] RST_THR_MAX   = 16'd2100;

	localparam logic [PCT_BITS-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_BITS-1:0] PCT_MID  = 7'd50;
	localparam logic [PCT_BITS-1:0] PCT_ZERO = 7'd0;

	// divider: one overflow check step (at shift 8) then quotient bits 7..0
	localparam int            QUO_BITS = 8;
	localparam int            NUM_BITS = 23;
	localparam int            SHD_BITS = 25;
	localparam logic [3:0]    DIV_FIRST = 4'd8;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEER_WAIT,
		ST_STEER_HIGH,
		ST_THR_WAIT,
		ST_THR_HIGH,
		ST_PREP_S,
		ST_DIV_S,
		ST_PREP_T,
		ST_DIV_T,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic cnt_clear;
		logic cnt_tick;
		logic high_set;
		logic high_inc;
		logic save_first;
		logic save_second;
		logic width_zero;
		logic prep;
		logic div_step;
		logic ch;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic lvl;
		logic hit;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

>>> rtl/rcpwm_in_if.sv
// ----------------------------------------------------------------------------
// rcpwm_in_if
// Tick channel: start flag and both pin levels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcpwm_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic steer_level;
	logic throttle_level;

	modport source (output valid, output start_req, output steer_level,
		output throttle_level, input ready);
	modport sink (input valid, input start_req, input steer_level,
		input throttle_level, output ready);
endinterface

>>> rtl/rcpwm_out_if.sv
// ----------------------------------------------------------------------------
// rcpwm_out_if
// Result channel: percents, validity flag and raw widths.
// ----------------------------------------------------------------------------
interface rcpwm_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  steering_pct;
	logic [6:0]  throttle_pct;
	logic        signal_ok;
	logic [15:0] steer_width;
	logic [15:0] throttle_width;

	modport source (output valid, output steering_pct, output throttle_pct,
		output signal_ok, output steer_width, output throttle_width, input ready);
	modport sink (input valid, input steering_pct, input throttle_pct,
		input signal_ok, input steer_width, input throttle_width, output ready);
endinterface

>>> rtl/rcpwm_ctrl.sv
// ----------------------------------------------------------------------------
// rcpwm_ctrl
// Sequencer: measures steering then throttle, then runs both percent divides.
// ----------------------------------------------------------------------------
module rcpwm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               start_req,
	output logic               in_ready,
	input  rcpwm_pkg::status_t sts,
	output rcpwm_pkg::cmd_t    cmd
);

	rcpwm_pkg::state_t state_q, state_nx;
	logic in_acc;
	logic is_high;
	logic meas_done;
	logic done_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcpwm_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		in_ready = (state_q == rcpwm_pkg::ST_IDLE) ||
			(state_q == rcpwm_pkg::ST_STEER_WAIT) || (state_q == rcpwm_pkg::ST_STEER_HIGH) ||
			(state_q == rcpwm_pkg::ST_THR_WAIT) || (state_q == rcpwm_pkg::ST_THR_HIGH);
		in_acc  = in_valid && in_ready;
		is_high = (state_q == rcpwm_pkg::ST_STEER_HIGH) || (state_q == rcpwm_pkg::ST_THR_HIGH);
		// a low sample in the high phase wins over the timeout
		if (is_high) begin
			meas_done = !sts.lvl || sts.hit;
			done_zero = sts.lvl;
		end else begin
			meas_done = sts.hit;
			done_zero = 1'b1;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rcpwm_pkg::ST_IDLE: begin
				if (in_acc && start_req) state_nx = rcpwm_pkg::ST_STEER_WAIT;
			end
			rcpwm_pkg::ST_STEER_WAIT: begin
				if (in_acc) begin
					if (meas_done) state_nx = rcpwm_pkg::ST_THR_WAIT;
					else if (sts.lvl) state_nx = rcpwm_pkg::ST_STEER_HIGH;
				end
			end
			rcpwm_pkg::ST_STEER_HIGH: begin
				if (in_acc && meas_done) state_nx = rcpwm_pkg::ST_THR_WAIT;
			end
			rcpwm_pkg::ST_THR_WAIT: begin
				if (in_acc) begin
					if (meas_done) state_nx = rcpwm_pkg::ST_PREP_S;
					else if (sts.lvl) state_nx = rcpwm_pkg::ST_THR_HIGH;
				end
			end
			rcpwm_pkg::ST_THR_HIGH: begin
				if (in_acc && meas_done) state_nx = rcpwm_pkg::ST_PREP_S;
			end
			rcpwm_pkg::ST_PREP_S: state_nx = rcpwm_pkg::ST_DIV_S;
			rcpwm_pkg::ST_DIV_S: begin
				if (sts.div_last) state_nx = rcpwm_pkg::ST_PREP_T;
			end
			rcpwm_pkg::ST_PREP_T: state_nx = rcpwm_pkg::ST_DIV_T;
			rcpwm_pkg::ST_DIV_T: begin
				if (sts.div_last) state_nx = rcpwm_pkg::ST_EMIT;
			end
			rcpwm_pkg::ST_EMIT: begin
				if (sts.out_free) state_nx = rcpwm_pkg::ST_IDLE;
			end
			default: state_nx = rcpwm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rcpwm_pkg::ST_IDLE: begin
				cmd.cnt_clear = in_acc && start_req;
			end
			rcpwm_pkg::ST_STEER_WAIT, rcpwm_pkg::ST_STEER_HIGH,
			rcpwm_pkg::ST_THR_WAIT, rcpwm_pkg::ST_THR_HIGH: begin
				cmd.ch          = (state_q == rcpwm_pkg::ST_THR_WAIT) ||
					(state_q == rcpwm_pkg::ST_THR_HIGH);
				cmd.cnt_tick    = in_acc;
				cmd.high_set    = in_acc && !is_high && sts.lvl;
				cmd.high_inc    = in_acc && is_high && sts.lvl;
				cmd.cnt_clear   = in_acc && meas_done;
				cmd.width_zero  = done_zero;
				cmd.save_first  = in_acc && meas_done && !cmd.ch;
				cmd.save_second = in_acc && meas_done && cmd.ch;
			end
			rcpwm_pkg::ST_PREP_S: cmd.prep = 1'b1;
			rcpwm_pkg::ST_DIV_S:  cmd.div_step = 1'b1;
			rcpwm_pkg::ST_PREP_T: begin
				cmd.prep = 1'b1;
				cmd.ch   = 1'b1;
			end
			rcpwm_pkg::ST_DIV_T: begin
				cmd.div_step = 1'b1;
				cmd.ch       = 1'b1;
			end
			rcpwm_pkg::ST_EMIT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/rcpwm_dp.sv
// ----------------------------------------------------------------------------
// rcpwm_dp
// Datapath: registers, tick counters, serial percent divider, result register.
// ----------------------------------------------------------------------------
module rcpwm_dp #(
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rcpwm_pkg::IDX_BITS-1:0]        cfg_index,
	input  logic [rcpwm_pkg::REG_BITS-1:0]        cfg_data,
	input  logic                                  steer_level,
	input  logic                                  throttle_level,
	input  rcpwm_pkg::cmd_t                       cmd,
	output rcpwm_pkg::status_t                    sts,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rcpwm_pkg::PCT_BITS-1:0]        steering_pct,
	output logic [rcpwm_pkg::PCT_BITS-1:0]        throttle_pct,
	output logic                                  signal_ok,
	output logic [rcpwm_pkg::REG_BITS-1:0]        steer_width,
	output logic [rcpwm_pkg::REG_BITS-1:0]        throttle_width
);

	localparam int CW = (COUNT_BITS > rcpwm_pkg::REG_BITS) ? COUNT_BITS : rcpwm_pkg::REG_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	// configuration
	logic [15:0] timeout_q, vmin_q, vmax_q, smin_q, smax_q, tmin_q, tmax_q;

	// measurement
	logic [COUNT_BITS-1:0] elapsed_q, high_q, first_q, second_q;
	logic [COUNT_BITS-1:0] elapsed_inc, high_inc, done_width;

	// divider
	logic [rcpwm_pkg::NUM_BITS-1:0] rem_q;
	logic [15:0]                    den_q;
	logic                           neg_q, eq_q, ge_q, ovf_q;
	logic [3:0]                     cnt_q;
	logic [rcpwm_pkg::QUO_BITS-1:0] quo_q;
	logic [rcpwm_pkg::PCT_BITS-1:0] spct_q, tpct_q;

	logic [15:0]                    w_sel, lo_sel, hi_sel, w1_16, w2_16;
	logic signed [16:0]             x_dif, d_dif;
	logic [15:0]                    x_mag, d_mag;
	logic [rcpwm_pkg::NUM_BITS-1:0] num_nx;
	logic [rcpwm_pkg::SHD_BITS-1:0] d_sh, r_ext;
	logic                           ge_sh;
	logic [rcpwm_pkg::QUO_BITS-1:0] quo_nx;
	logic [rcpwm_pkg::PCT_BITS-1:0] pct_nx;
	logic                           ok;

	logic                           out_valid_q, sok_q;
	logic [rcpwm_pkg::PCT_BITS-1:0] ospct_q, otpct_q;
	logic [15:0]                    osw_q, otw_q;

	function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] w);
		logic [CW-1:0] we;
		we = CW'(w);
		return (we > CW'(16'hFFFF)) ? 16'hFFFF : we[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rcpwm_pkg::RST_TIMEOUT;
			vmin_q    <= rcpwm_pkg::RST_VALID_MIN;
			vmax_q    <= rcpwm_pkg::RST_VALID_MAX;
			smin_q    <= rcpwm_pkg::RST_STEER_MIN;
			smax_q    <= rcpwm_pkg::RST_STEER_MAX;
			tmin_q    <= rcpwm_pkg::RST_THR_MIN;
			tmax_q    <= rcpwm_pkg::RST_THR_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcpwm_pkg::REG_TIMEOUT:   timeout_q <= cfg_data;
				rcpwm_pkg::REG_VALID_MIN: vmin_q    <= cfg_data;
				rcpwm_pkg::REG_VALID_MAX: vmax_q    <= cfg_data;
				rcpwm_pkg::REG_STEER_MIN: smin_q    <= cfg_data;
				rcpwm_pkg::REG_STEER_MAX: smax_q    <= cfg_data;
				rcpwm_pkg::REG_THR_MIN:   tmin_q    <= cfg_data;
				rcpwm_pkg::REG_THR_MAX:   tmax_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturating tick counters
	always_comb begin
		elapsed_inc  = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;
		high_inc     = (high_q == CNT_MAX) ? high_q : high_q + 1'b1;
		done_width   = cmd.width_zero ? '0 : high_q;
		sts.lvl      = cmd.ch ? throttle_level : steer_level;
		sts.hit      = CW'(elapsed_inc) >= CW'(timeout_q);
		sts.div_last = (cnt_q == 4'd0);
		sts.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			high_q    <= '0;
		end else if (cmd.cnt_clear) begin
			elapsed_q <= '0;
			high_q    <= '0;
		end else begin
			if (cmd.cnt_tick) elapsed_q <= elapsed_inc;
			if (cmd.high_set) high_q <= COUNT_BITS'(1);
			else if (cmd.high_inc) high_q <= high_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.save_first)  first_q  <= done_width;
		if (cmd.save_second) second_q <= done_width;
	end

	// operand preparation: |x - lo| * 100 and |hi - lo|
	always_comb begin
		w1_16  = sat16(first_q);
		w2_16  = sat16(second_q);
		w_sel  = cmd.ch ? w2_16 : w1_16;
		lo_sel = cmd.ch ? tmin_q : smin_q;
		hi_sel = cmd.ch ? tmax_q : smax_q;
		x_dif  = $signed({1'b0, w_sel}) - $signed({1'b0, lo_sel});
		d_dif  = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
		x_mag  = x_dif[16] ? 16'(-x_dif) : x_dif[15:0];
		d_mag  = d_dif[16] ? 16'(-d_dif) : d_dif[15:0];
		num_nx = rcpwm_pkg::NUM_BITS'(x_mag) * rcpwm_pkg::NUM_BITS'(7'd100);
	end

	// one restoring step: compare against den << cnt
	always_comb begin
		d_sh   = rcpwm_pkg::SHD_BITS'(den_q) << cnt_q;
		r_ext  = rcpwm_pkg::SHD_BITS'(rem_q);
		ge_sh  = r_ext >= d_sh;
		quo_nx = quo_q;
		if (cnt_q != rcpwm_pkg::DIV_FIRST && ge_sh) quo_nx[cnt_q[2:0]] = 1'b1;
		if (eq_q) begin
			pct_nx = ge_q ? rcpwm_pkg::PCT_FULL : rcpwm_pkg::PCT_ZERO;
		end else if (neg_q) begin
			pct_nx = rcpwm_pkg::PCT_ZERO;
		end else if (ovf_q || quo_nx > rcpwm_pkg::QUO_BITS'(rcpwm_pkg::PCT_FULL)) begin
			pct_nx = rcpwm_pkg::PCT_FULL;
		end else begin
			pct_nx = quo_nx[rcpwm_pkg::PCT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.prep) begin
			cnt_q <= rcpwm_pkg::DIV_FIRST;
		end else if (cmd.div_step && cnt_q != 4'd0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			rem_q <= num_nx;
			den_q <= d_mag;
			neg_q <= x_dif[16] ^ d_dif[16];
			eq_q  <= (lo_sel == hi_sel);
			ge_q  <= (w_sel >= lo_sel);
			ovf_q <= 1'b0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (cnt_q == rcpwm_pkg::DIV_FIRST) begin
				ovf_q <= ge_sh;
			end else if (ge_sh) begin
				rem_q <= rcpwm_pkg::NUM_BITS'(r_ext - d_sh);
			end
			quo_q <= quo_nx;
			if (cnt_q == 4'd0) begin
				if (cmd.ch) tpct_q <= pct_nx;
				else spct_q <= pct_nx;
			end
		end
	end

	// window check on the full-width counts
	assign ok = (CW'(first_q) >= CW'(vmin_q)) && (CW'(first_q) <= CW'(vmax_q)) &&
		(CW'(second_q) >= CW'(vmin_q)) && (CW'(second_q) <= CW'(vmax_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sok_q   <= ok;
			ospct_q <= ok ? spct_q : rcpwm_pkg::PCT_MID;
			otpct_q <= ok ? tpct_q : rcpwm_pkg::PCT_MID;
			osw_q   <= w1_16;
			otw_q   <= w2_16;
		end
	end

	assign out_valid      = out_valid_q;
	assign steering_pct   = ospct_q;
	assign throttle_pct   = otpct_q;
	assign signal_ok      = sok_q;
	assign steer_width    = osw_q;
	assign throttle_width = otw_q;

endmodule

>>> rtl/rc_pwm_two_channel_decoder.sv
// ----------------------------------------------------------------------------
// rc_pwm_two_channel_decoder
// Two-channel RC pulse-width decoder with percent mapping.
// ----------------------------------------------------------------------------
// Throughput: one tick word per cycle while a measurement runs or the block
// is idle. After the tick that ends the throttle channel, input ready drops
// through two percent divides (operand prep plus 9 serial restoring steps
// each) and one load state, which waits while the previous result word is
// still unaccepted; the result word is valid on the next cycle.
// Reset clears the sequencer, counters and output valid, loads the defaults.
// ----------------------------------------------------------------------------
module rc_pwm_two_channel_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rcpwm_in_if.sink                       in,
	rcpwm_out_if.source                    out,
	input  logic                           cfg_we,
	input  logic [rcpwm_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [rcpwm_pkg::REG_BITS-1:0] cfg_data
);

	rcpwm_pkg::cmd_t    cmd;
	rcpwm_pkg::status_t sts;

	rcpwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in.valid),
		.start_req (in.start_req),
		.in_ready  (in.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rcpwm_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.steer_level    (in.steer_level),
		.throttle_level (in.throttle_level),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out.valid),
		.out_ready      (out.ready),
		.steering_pct   (out.steering_pct),
		.throttle_pct   (out.throttle_pct),
		.signal_ok      (out.signal_ok),
		.steer_width    (out.steer_width),
		.throttle_width (out.throttle_width)
	);

endmodule

>>> test/rc_pwm_two_channel_decoder_tb.sv
// ----------------------------------------------------------------------------
// rc_pwm_two_channel_decoder_tb
// Drives microsecond tick words into the decoder and checks every result word
// against a cycle-free model of the measurement sequencer. A directed table
// covers register extremes, timeouts, equal and reversed map bounds and an
// inverted valid window. Randomized phases with small timing values follow.
// ----------------------------------------------------------------------------
module rc_pwm_two_channel_decoder_tb;

	localparam int          CNT_BITS    = 16;
	localparam int unsigned CNT_MAX     = (1 << CNT_BITS) - 1;
	localparam int          DRAIN       = 30;
	localparam int          PHASES      = 8;
	localparam int unsigned PHASE_TICKS = 76;
	localparam int          LIMIT       = 400000;

	typedef struct packed {
		logic [rcpwm_pkg::PCT_BITS-1:0] steering_pct;
		logic [rcpwm_pkg::PCT_BITS-1:0] throttle_pct;
		logic                           signal_ok;
		logic [15:0]                    steer_width;
		logic [15:0]                    throttle_width;
	} pwm_result_t;

	typedef struct packed {
		bit                             is_cfg;
		logic [rcpwm_pkg::IDX_BITS-1:0] idx;
		logic [rcpwm_pkg::REG_BITS-1:0] data;
		bit                             st;
		bit                             sl;
		bit                             tl;
		bit                             typed;
		pwm_result_t                    res;
	} plan_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [rcpwm_pkg::IDX_BITS-1:0] cfg_index;
	logic [rcpwm_pkg::REG_BITS-1:0] cfg_data;

	rcpwm_in_if  tick_if ();
	rcpwm_out_if res_if ();

	rc_pwm_two_channel_decoder #(.COUNT_BITS(CNT_BITS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (tick_if),
		.out       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// decoder model state
	logic [rcpwm_pkg::REG_BITS-1:0] reg_file [0:6];
	rcpwm_pkg::state_t              dec_phase;
	int unsigned                    dec_elapsed;
	int unsigned                    dec_high;
	int unsigned                    dec_steer_width;

	pwm_result_t pending_readings [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	int unsigned sent_ticks;
	bit          calm;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned sat_inc(input int unsigned v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 1;
	endfunction

	function automatic logic [rcpwm_pkg::PCT_BITS-1:0] map_pct(input int unsigned w,
			input logic [rcpwm_pkg::REG_BITS-1:0] lo,
			input logic [rcpwm_pkg::REG_BITS-1:0] hi);
		longint num;
		longint den;
		longint q;
		if (lo == hi)
			return (w >= lo) ? rcpwm_pkg::PCT_FULL : rcpwm_pkg::PCT_ZERO;
		num = (longint'(w) - longint'(lo)) * 100;
		den = longint'(hi) - longint'(lo);
		q = num / den;
		if (q < 0)
			q = 0;
		if (q > 100)
			q = 100;
		return q[rcpwm_pkg::PCT_BITS-1:0];
	endfunction

	// one tick through the sequencer; returns 1 when a reading completes
	function automatic bit decode_tick(input bit st, input bit sl, input bit tl,
			output pwm_result_t r);
		bit          lvl;
		bit          done;
		bit          thr;
		bit          ok;
		int unsigned w;
		r = '0;
		done = 1'b0;
		w = 0;
		if (dec_phase == rcpwm_pkg::ST_IDLE) begin
			if (st) begin
				dec_phase = rcpwm_pkg::ST_STEER_WAIT;
				dec_elapsed = 0;
				dec_high = 0;
			end
			return 1'b0;
		end
		thr = (dec_phase == rcpwm_pkg::ST_THR_WAIT || dec_phase == rcpwm_pkg::ST_THR_HIGH);
		lvl = thr ? tl : sl;
		dec_elapsed = sat_inc(dec_elapsed);
		if (dec_phase == rcpwm_pkg::ST_STEER_HIGH || dec_phase == rcpwm_pkg::ST_THR_HIGH) begin
			if (!lvl) begin
				done = 1'b1;
				w = dec_high;
			end else
				dec_high = sat_inc(dec_high);
		end else if (lvl) begin
			dec_high = 1;
			dec_phase = thr ? rcpwm_pkg::ST_THR_HIGH : rcpwm_pkg::ST_STEER_HIGH;
		end
		if (!done && dec_elapsed >= reg_file[rcpwm_pkg::REG_TIMEOUT]) begin
			done = 1'b1;
			w = 0;
		end
		if (!done)
			return 1'b0;
		dec_elapsed = 0;
		dec_high = 0;
		if (!thr) begin
			dec_steer_width = w;
			dec_phase = rcpwm_pkg::ST_THR_WAIT;
			return 1'b0;
		end
		dec_phase = rcpwm_pkg::ST_IDLE;
		ok = dec_steer_width >= reg_file[rcpwm_pkg::REG_VALID_MIN] &&
			dec_steer_width <= reg_file[rcpwm_pkg::REG_VALID_MAX] &&
			w >= reg_file[rcpwm_pkg::REG_VALID_MIN] &&
			w <= reg_file[rcpwm_pkg::REG_VALID_MAX];
		if (ok) begin
			r.steering_pct = map_pct(dec_steer_width, reg_file[rcpwm_pkg::REG_STEER_MIN],
				reg_file[rcpwm_pkg::REG_STEER_MAX]);
			r.throttle_pct = map_pct(w, reg_file[rcpwm_pkg::REG_THR_MIN],
				reg_file[rcpwm_pkg::REG_THR_MAX]);
		end else begin
			r.steering_pct = rcpwm_pkg::PCT_MID;
			r.throttle_pct = rcpwm_pkg::PCT_MID;
		end
		r.signal_ok = ok;
		r.steer_width = (dec_steer_width > 65535) ? 16'hFFFF : dec_steer_width[15:0];
		r.throttle_width = (w > 65535) ? 16'hFFFF : w[15:0];
		return 1'b1;
	endfunction

	task automatic send_tick(input bit st, input bit sl, input bit tl,
			input bit typed = 1'b0, input pwm_result_t fixed = '0);
		int unsigned gap;
		pwm_result_t r;
		bit          got;
		gap = calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			tick_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_if.valid <= 1'b1;
		tick_if.start_req <= st;
		tick_if.steer_level <= sl;
		tick_if.throttle_level <= tl;
		@(posedge clk);
		while (!tick_if.ready) @(posedge clk);
		sent_ticks++;
		got = decode_tick(st, sl, tl, r);
		if (typed)
			pending_readings.push_back(fixed);
		else if (got)
			pending_readings.push_back(r);
	endtask

	task automatic write_reg(input logic [rcpwm_pkg::IDX_BITS-1:0] idx,
			input logic [rcpwm_pkg::REG_BITS-1:0] data, input bit last);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		reg_file[idx] = data;
		@(posedge clk);
		if (last)
			cfg_we <= 1'b0;
	endtask

	// hold the sender until every reading is back and the divider is done
	task automatic settle();
		tick_if.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic int unsigned pick_width();
		int unsigned lo;
		int unsigned hi;
		int unsigned r;
		r = $urandom_range(0, 9);
		lo = (reg_file[rcpwm_pkg::REG_VALID_MIN] > 2) ?
			reg_file[rcpwm_pkg::REG_VALID_MIN] - 2 : 1;
		hi = reg_file[rcpwm_pkg::REG_VALID_MAX] + 2;
		if (hi > 60)
			hi = 60;
		if (hi < lo)
			hi = lo + 5;
		if (r < 7)
			return $urandom_range(hi, lo);
		if (r < 9)
			return $urandom_range(60, 1);
		return 0;
	endfunction

	// low lead-in, pulse of w ticks, one low tick; the other pin is noise
	task automatic drive_channel(input bit thr, input int unsigned pre,
			input int unsigned w);
		bit lvl;
		bit other;
		for (int unsigned k = 0; k <= pre + w; k++) begin
			lvl = (k >= pre && k < pre + w);
			other = 1'($urandom_range(0, 1));
			send_tick($urandom_range(0, 5) == 0, thr ? other : lvl, thr ? lvl : other);
		end
	endtask

	task automatic run_phase(input int p);
		logic [rcpwm_pkg::REG_BITS-1:0] v [0:6];
		int unsigned                    base;
		bit                             lvl;
		v[rcpwm_pkg::REG_TIMEOUT]   = rcpwm_pkg::REG_BITS'($urandom_range(70, 8));
		v[rcpwm_pkg::REG_VALID_MIN] = rcpwm_pkg::REG_BITS'($urandom_range(12, 0));
		v[rcpwm_pkg::REG_VALID_MAX] = rcpwm_pkg::REG_BITS'(v[rcpwm_pkg::REG_VALID_MIN] +
			$urandom_range(25, 0));
		v[rcpwm_pkg::REG_STEER_MIN] = rcpwm_pkg::REG_BITS'($urandom_range(20, 0));
		v[rcpwm_pkg::REG_STEER_MAX] = rcpwm_pkg::REG_BITS'($urandom_range(45, 0));
		v[rcpwm_pkg::REG_THR_MIN]   = rcpwm_pkg::REG_BITS'($urandom_range(20, 0));
		v[rcpwm_pkg::REG_THR_MAX]   = rcpwm_pkg::REG_BITS'($urandom_range(45, 0));
		case (p)
			0: v[rcpwm_pkg::REG_TIMEOUT] = '0;
			1: begin
				v[rcpwm_pkg::REG_TIMEOUT] = '1;
				v[rcpwm_pkg::REG_VALID_MIN] = '0;
				v[rcpwm_pkg::REG_VALID_MAX] = '1;
			end
			2: begin
				v[rcpwm_pkg::REG_VALID_MIN] = rcpwm_pkg::REG_BITS'($urandom_range(12, 3));
				v[rcpwm_pkg::REG_VALID_MAX] = rcpwm_pkg::REG_BITS'(
					v[rcpwm_pkg::REG_VALID_MIN] - $urandom_range(3, 1));
			end
			3: begin
				v[rcpwm_pkg::REG_STEER_MAX] = v[rcpwm_pkg::REG_STEER_MIN];
				v[rcpwm_pkg::REG_THR_MAX] = v[rcpwm_pkg::REG_THR_MIN];
			end
			default: ;
		endcase
		settle();
		for (int i = 0; i < 7; i++)
			write_reg(rcpwm_pkg::IDX_BITS'(i), v[i], i == 6);
		base = sent_ticks;
		while (sent_ticks - base < PHASE_TICKS) begin
			calm = (p == 5) || ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 8) begin
				send_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				drive_channel(1'b0, $urandom_range(3, 0), pick_width());
				drive_channel(1'b1, $urandom_range(3, 0), pick_width());
			end else begin
				repeat ($urandom_range(6, 1))
					send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
		end
		// close any open measurement so the next register write sees idle
		while (dec_phase != rcpwm_pkg::ST_IDLE) begin
			lvl = (dec_phase == rcpwm_pkg::ST_STEER_WAIT ||
				dec_phase == rcpwm_pkg::ST_THR_WAIT);
			send_tick(1'b0, lvl, lvl);
		end
	endtask

	function automatic plan_row_t tick_row(input bit st, input bit sl, input bit tl);
		plan_row_t row;
		row = '0;
		row.st = st;
		row.sl = sl;
		row.tl = tl;
		return row;
	endfunction

	function automatic plan_row_t check_row(input bit st, input bit sl, input bit tl,
			input logic [rcpwm_pkg::PCT_BITS-1:0] sp,
			input logic [rcpwm_pkg::PCT_BITS-1:0] tp, input bit ok,
			input logic [15:0] sw, input logic [15:0] tw);
		plan_row_t row;
		row = tick_row(st, sl, tl);
		row.typed = 1'b1;
		row.res = '{sp, tp, ok, sw, tw};
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [rcpwm_pkg::IDX_BITS-1:0] idx,
			input logic [rcpwm_pkg::REG_BITS-1:0] data);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	// result sink with random stall, checks each word against the oldest reading
	initial begin
		pwm_result_t e;
		int unsigned stall;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 12);
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			if (pending_readings.size() == 0) begin
				$display("%0t: unexpected result word, expected none, got %h", $time,
					{res_if.steering_pct, res_if.throttle_pct, res_if.signal_ok,
					res_if.steer_width, res_if.throttle_width});
				mismatches++;
			end else begin
				e = pending_readings.pop_front();
				if (res_if.steering_pct !== e.steering_pct) begin
					$display("%0t: steering_pct expected %0d, got %0d", $time,
						e.steering_pct, res_if.steering_pct);
					mismatches++;
				end
				if (res_if.throttle_pct !== e.throttle_pct) begin
					$display("%0t: throttle_pct expected %0d, got %0d", $time,
						e.throttle_pct, res_if.throttle_pct);
					mismatches++;
				end
				if (res_if.signal_ok !== e.signal_ok) begin
					$display("%0t: signal_ok expected %0d, got %0d", $time,
						e.signal_ok, res_if.signal_ok);
					mismatches++;
				end
				if (res_if.steer_width !== e.steer_width) begin
					$display("%0t: steer_width expected %0d, got %0d", $time,
						e.steer_width, res_if.steer_width);
					mismatches++;
				end
				if (res_if.throttle_width !== e.throttle_width) begin
					$display("%0t: throttle_width expected %0d, got %0d", $time,
						e.throttle_width, res_if.throttle_width);
					mismatches++;
				end
			end
		end
	end

	initial begin
		plan_row_t plan [$];
		plan_row_t row;
		sent_ticks = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		tick_if.valid <= 1'b0;
		tick_if.start_req <= 1'b0;
		tick_if.steer_level <= 1'b0;
		tick_if.throttle_level <= 1'b0;
		reg_file = '{rcpwm_pkg::RST_TIMEOUT, rcpwm_pkg::RST_VALID_MIN,
			rcpwm_pkg::RST_VALID_MAX, rcpwm_pkg::RST_STEER_MIN, rcpwm_pkg::RST_STEER_MAX,
			rcpwm_pkg::RST_THR_MIN, rcpwm_pkg::RST_THR_MAX};
		dec_phase = rcpwm_pkg::ST_IDLE;
		dec_elapsed = 0;
		dec_high = 0;
		dec_steer_width = 0;

		// reset defaults: idle tick ignored, busy start ignored, short pulses invalid
		plan.push_back(tick_row(1'b0, 1'b1, 1'b1));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b1));
		plan.push_back(check_row(1'b1, 1'b1, 1'b0, rcpwm_pkg::PCT_MID, rcpwm_pkg::PCT_MID,
			1'b0, 16'd2, 16'd1));
		// shortest timeout: high on the first tick still reads zero
		plan.push_back(cfg_row(rcpwm_pkg::REG_TIMEOUT, 16'd1));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b1));
		plan.push_back(check_row(1'b0, 1'b0, 1'b0, rcpwm_pkg::PCT_MID, rcpwm_pkg::PCT_MID,
			1'b0, 16'd0, 16'd0));
		// widest window, equal steering bounds, reversed throttle bounds (clamped)
		plan.push_back(cfg_row(rcpwm_pkg::REG_TIMEOUT, 16'hFFFF));
		plan.push_back(cfg_row(rcpwm_pkg::REG_VALID_MIN, 16'd0));
		plan.push_back(cfg_row(rcpwm_pkg::REG_VALID_MAX, 16'hFFFF));
		plan.push_back(cfg_row(rcpwm_pkg::REG_STEER_MIN, 16'd3));
		plan.push_back(cfg_row(rcpwm_pkg::REG_STEER_MAX, 16'd3));
		plan.push_back(cfg_row(rcpwm_pkg::REG_THR_MIN, 16'd4));
		plan.push_back(cfg_row(rcpwm_pkg::REG_THR_MAX, 16'd2));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b1));
		plan.push_back(check_row(1'b0, 1'b1, 1'b0, rcpwm_pkg::PCT_ZERO, rcpwm_pkg::PCT_FULL,
			1'b1, 16'd1, 16'd1));
		// inverted window rejects everything
		plan.push_back(cfg_row(rcpwm_pkg::REG_VALID_MIN, 16'd2));
		plan.push_back(cfg_row(rcpwm_pkg::REG_VALID_MAX, 16'd1));
		plan.push_back(tick_row(1'b1, 1'b0, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b1, 1'b0));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b1));
		plan.push_back(tick_row(1'b0, 1'b0, 1'b1));
		plan.push_back(check_row(1'b0, 1'b0, 1'b0, rcpwm_pkg::PCT_MID, rcpwm_pkg::PCT_MID,
			1'b0, 16'd2, 16'd1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan.size(); i++) begin
			row = plan[i];
			if (row.is_cfg) begin
				if (i == 0 || !plan[i-1].is_cfg)
					settle();
				write_reg(row.idx, row.data, i + 1 == plan.size() || !plan[i+1].is_cfg);
			end else
				send_tick(row.st, row.sl, row.tl, row.typed, row.res);
		end

		for (int p = 0; p < PHASES; p++)
			run_phase(p);

		tick_if.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
